// ===== src/yuyv_to_rgb_framebuffer_writer_core_defines.svh =====
// Assertion macros shared by the YUYV to RGB framebuffer writer RTL.
// Expects clk and rst_n in the scope of each use.
`ifndef YUYV_TO_RGB_FRAMEBUFFER_WRITER_CORE_DEFINES_SVH
`define YUYV_TO_RGB_FRAMEBUFFER_WRITER_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define YRFW_ASSERT_NOW(label, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define YRFW_ASSERT_NEXT(label, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/yrfw_pkg.sv =====
// Shared types and constants for the YUYV to RGB framebuffer writer.
// No dependencies.
package yrfw_pkg;

    localparam int DEF_MAX_FRAME_DIM = 4096;
    localparam int ADDR_W     = 28;
    localparam int BASE_W     = 27;   // pixel index bits kept before byte scaling
    localparam int PIX_W      = 24;
    localparam int DIM_W      = 13;
    localparam int OFS_W      = 12;
    localparam int CMP_W      = 14;   // holds any register value + 1 and the dim limit
    localparam int CFG_IDX_W  = 3;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH  = 3'd0,
        REG_FRAME_HEIGHT = 3'd1,
        REG_SCREEN_WIDTH = 3'd2,
        REG_X_OFFSET     = 3'd3,
        REG_Y_OFFSET     = 3'd4,
        REG_PIXEL_MODE   = 3'd5
    } cfg_index_t;

    // Address terms and frame flag handed from address path to merge stage
    typedef struct packed {
        logic [BASE_W-1:0] row_term;
        logic [BASE_W-1:0] col_term;
        logic              eof;
    } addr_info_t;

endpackage

// ===== src/yrfw_lane.sv =====
// One pixel conversion lane: YUV to clamped RGB, packed as RGB565 or RGB888.
// Depends on yrfw_pkg. Two register stages, advanced by en.
module yrfw_lane
    import yrfw_pkg::*;
(
    input  logic             clk,
    input  logic             en,
    input  logic [7:0]       y,
    input  logic [7:0]       u,
    input  logic [7:0]       v,
    input  logic             pixel_mode,
    output logic [PIX_W-1:0] pix
);

    // Reciprocal scaling: floor(C*n/10000) == (n*ceil(C*2^SH/10000)) >> SH for n <= 128
    localparam int RECIP_SH = 21;
    localparam int K_W      = 22;
    localparam int PROD_W   = 29;
    localparam longint unsigned DIV  = 10000;
    localparam longint unsigned ONE  = longint'(1) << RECIP_SH;
    localparam longint unsigned K_RV = (14075 * ONE + DIV - 1) / DIV;
    localparam longint unsigned K_GU = (3455 * ONE + DIV - 1) / DIV;
    localparam longint unsigned K_GV = (7169 * ONE + DIV - 1) / DIV;
    localparam longint unsigned K_BU = (17790 * ONE + DIV - 1) / DIV;
    localparam logic [K_W-1:0] KRV = K_W'(K_RV);
    localparam logic [K_W-1:0] KGU = K_W'(K_GU);
    localparam logic [K_W-1:0] KGV = K_W'(K_GV);
    localparam logic [K_W-1:0] KBU = K_W'(K_BU);

    logic              u_neg, v_neg;
    logic [7:0]        mag_u, mag_v;
    logic [PROD_W-1:0] p_rv, p_gu, p_gv, p_bu;

    logic              u_neg_reg, v_neg_reg;
    logic [7:0]        y_reg;
    logic [7:0]        q_rv_reg, q_gu_reg, q_gv_reg, q_bu_reg;
    logic [PIX_W-1:0]  pix_reg, pix_next;

    logic [10:0]       off_r, off_gu, off_gv, off_b, y_ext;
    logic signed [10:0] r_s, g_s, b_s;
    logic [7:0]        r8, g8, b8;

    // Chroma magnitudes and reciprocal products
    assign u_neg = ~u[7];
    assign v_neg = ~v[7];
    assign mag_u = u[7] ? {1'b0, u[6:0]} : (8'd128 - u);
    assign mag_v = v[7] ? {1'b0, v[6:0]} : (8'd128 - v);
    assign p_rv  = PROD_W'(mag_v) * PROD_W'(KRV);
    assign p_gu  = PROD_W'(mag_u) * PROD_W'(KGU);
    assign p_gv  = PROD_W'(mag_v) * PROD_W'(KGV);
    assign p_bu  = PROD_W'(mag_u) * PROD_W'(KBU);

    // Stage 1: quotient magnitudes
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            y_reg     <= y;
            u_neg_reg <= u_neg;
            v_neg_reg <= v_neg;
            q_rv_reg  <= p_rv[RECIP_SH+7:RECIP_SH];
            q_gu_reg  <= p_gu[RECIP_SH+7:RECIP_SH];
            q_gv_reg  <= p_gv[RECIP_SH+7:RECIP_SH];
            q_bu_reg  <= p_bu[RECIP_SH+7:RECIP_SH];
        end
    end

    // Signed offsets: R floors (a negative V term is never exact), G and B truncate
    assign y_ext  = {3'b000, y_reg};
    assign off_r  = v_neg_reg ? (11'd0 - {3'b000, q_rv_reg} - 11'd1) : {3'b000, q_rv_reg};
    assign off_gu = u_neg_reg ? (11'd0 - {3'b000, q_gu_reg}) : {3'b000, q_gu_reg};
    assign off_gv = v_neg_reg ? (11'd0 - {3'b000, q_gv_reg}) : {3'b000, q_gv_reg};
    assign off_b  = u_neg_reg ? (11'd0 - {3'b000, q_bu_reg}) : {3'b000, q_bu_reg};
    assign r_s    = $signed(y_ext + off_r);
    assign g_s    = $signed(y_ext - off_gu - off_gv);
    assign b_s    = $signed(y_ext + off_b);

    // Clamp to 0..255
    always_comb
    begin
        r8 = (r_s < 0) ? 8'd0 : ((r_s > 11'sd255) ? 8'd255 : r_s[7:0]);
        g8 = (g_s < 0) ? 8'd0 : ((g_s > 11'sd255) ? 8'd255 : g_s[7:0]);
        b8 = (b_s < 0) ? 8'd0 : ((b_s > 11'sd255) ? 8'd255 : b_s[7:0]);
        if (pixel_mode)
            pix_next = {r8, g8, b8};
        else
            pix_next = {8'd0, r8[7:3], g8[7:2], b8[7:3]};
    end

    // Stage 2: packed pixel
    always_ff @(posedge clk)
    begin
        if (en)
            pix_reg <= pix_next;
    end

    assign pix = pix_reg;

endmodule

// ===== src/yrfw_addr.sv =====
// Raster counters and framebuffer address terms for one YUYV pair.
// Depends on yrfw_pkg. Two register stages, advanced by en.
module yrfw_addr
    import yrfw_pkg::*;
#(
    parameter int MAX_FRAME_DIM = DEF_MAX_FRAME_DIM
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  logic             en,
    input  logic [DIM_W-1:0] frame_width,
    input  logic [DIM_W-1:0] frame_height,
    input  logic [DIM_W-1:0] screen_width,
    input  logic [OFS_W-1:0] x_offset,
    input  logic [OFS_W-1:0] y_offset,
    output addr_info_t       info
);

    localparam int PCW = $clog2(MAX_FRAME_DIM / 2);
    localparam int RW  = $clog2(MAX_FRAME_DIM);
    localparam int YW  = ((RW > OFS_W) ? RW : OFS_W) + 1;
    localparam logic [CMP_W-1:0] MAX_PAIRS = CMP_W'(MAX_FRAME_DIM / 2);
    localparam logic [CMP_W-1:0] MAX_ROWS  = CMP_W'(MAX_FRAME_DIM);

    logic [PCW-1:0]    pair_column_reg, pair_column_next;
    logic [RW-1:0]     row_count_reg, row_count_next;
    logic [CMP_W-1:0]  pairs, rows;
    logic              last_pair, last_row;

    logic [YW-1:0]     row_sum_reg;
    logic [BASE_W-1:0] col1_reg;
    logic              eof1_reg;
    logic [BASE_W-1:0] prod_reg;
    logic [BASE_W-1:0] col2_reg;
    logic              eof2_reg;

    // Effective frame size in pairs and rows
    always_comb
    begin
        pairs = CMP_W'(frame_width[DIM_W-1:1]);
        if (pairs == '0)
            pairs = CMP_W'(1);
        if (pairs > MAX_PAIRS)
            pairs = MAX_PAIRS;
        rows = CMP_W'(frame_height);
        if (rows == '0)
            rows = CMP_W'(1);
        if (rows > MAX_ROWS)
            rows = MAX_ROWS;
    end

    assign last_pair = (CMP_W'(pair_column_reg) + CMP_W'(1)) >= pairs;
    assign last_row  = (CMP_W'(row_count_reg) + CMP_W'(1)) >= rows;

    // Counter advance
    always_comb
    begin
        pair_column_next = pair_column_reg;
        row_count_next   = row_count_reg;
        if (accept)
        begin
            if (last_pair)
            begin
                pair_column_next = '0;
                row_count_next   = last_row ? '0 : row_count_reg + RW'(1);
            end
            else
                pair_column_next = pair_column_reg + PCW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pair_column_reg <= '0;
            row_count_reg   <= '0;
        end
        else
        begin
            pair_column_reg <= pair_column_next;
            row_count_reg   <= row_count_next;
        end
    end

    // Stage 1: row sum and column term
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            row_sum_reg <= YW'(row_count_reg) + YW'(y_offset);
            col1_reg    <= BASE_W'({pair_column_reg, 1'b0}) + BASE_W'(x_offset);
            eof1_reg    <= last_pair & last_row;
        end
    end

    // Stage 2: row times screen width
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= BASE_W'(row_sum_reg) * BASE_W'(screen_width);
            col2_reg <= col1_reg;
            eof2_reg <= eof1_reg;
        end
    end

    assign info.row_term = prod_reg;
    assign info.col_term = col2_reg;
    assign info.eof      = eof2_reg;

endmodule

// ===== src/yrfw_merge.sv =====
// Merge stage: combines both lane pixels and the address into two output requests.
// Depends on yrfw_pkg and the assertion macro header.
`include "yuyv_to_rgb_framebuffer_writer_core_defines.svh"
module yrfw_merge
    import yrfw_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  addr_info_t       info,
    input  logic [PIX_W-1:0] pix0,
    input  logic [PIX_W-1:0] pix1,
    input  logic             pixel_mode,
    output logic             load_ready,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [55:0]      m_axis_tdata,   // byte_address[27:0], pixel_data[51:28], zero
    output logic             m_axis_tlast,   // second_of_pair
    output logic             m_axis_tuser    // end_of_frame
);

    logic              full_reg, full_next;
    logic              sel_reg, sel_next;
    logic [ADDR_W-1:0] addr0_reg, addr1_reg;
    logic [PIX_W-1:0]  pix0_reg, pix1_reg;
    logic              eof_reg;
    logic [BASE_W-1:0] base0, base1;
    logic [ADDR_W-1:0] addr0, addr1;
    logic              out_take;

    // Pixel index to byte address, modulo 2^28
    assign base0 = info.row_term + info.col_term;
    assign base1 = base0 + BASE_W'(1);
    assign addr0 = pixel_mode ? ADDR_W'({base0, 2'b00}) : ADDR_W'({base0, 1'b0});
    assign addr1 = pixel_mode ? ADDR_W'({base1, 2'b00}) : ADDR_W'({base1, 1'b0});

    assign out_take   = full_reg & m_axis_tready;
    assign load_ready = ~full_reg | (sel_reg & m_axis_tready);

    // Pair sequencing
    always_comb
    begin
        full_next = full_reg;
        sel_next  = sel_reg;
        if (load)
        begin
            full_next = 1'b1;
            sel_next  = 1'b0;
        end
        else if (out_take)
        begin
            if (sel_reg)
                full_next = 1'b0;
            else
                sel_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
            sel_reg  <= 1'b0;
        end
        else
        begin
            full_reg <= full_next;
            sel_reg  <= sel_next;
        end
    end

    // Pair payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            addr0_reg <= addr0;
            addr1_reg <= addr1;
            pix0_reg  <= pix0;
            pix1_reg  <= pix1;
            eof_reg   <= info.eof;
        end
    end

    assign m_axis_tvalid = full_reg;
    assign m_axis_tlast  = sel_reg;
    assign m_axis_tuser  = sel_reg & eof_reg;
    assign m_axis_tdata  = sel_reg ? {4'b0000, pix1_reg, addr1_reg}
                                   : {4'b0000, pix0_reg, addr0_reg};

    `YRFW_ASSERT_NEXT(a_second_follows, m_axis_tvalid && !m_axis_tlast && m_axis_tready, m_axis_tvalid && m_axis_tlast, "second pixel of pair missing")
    `YRFW_ASSERT_NEXT(a_drain_empty, m_axis_tvalid && m_axis_tlast && m_axis_tready && !load, !m_axis_tvalid, "pair delivered twice")
    `YRFW_ASSERT_NEXT(a_load_first, load, m_axis_tvalid && !m_axis_tlast, "new pair does not start on first pixel")

endmodule

// ===== src/yuyv_to_rgb_framebuffer_writer_core.sv =====
// Flow: an accepted request passes lane and address stages 1 and 2, then loads into the merge
// stage, which offers its first pixel; the second follows in the cycle after the first is taken.
// Throughput: a request every cycle until the output fills; sustained rate is set by the
// merge stage, one pixel per cycle while m_axis_tready is high on the single output channel.
// Reset: rst_n asynchronous active low; counters to zero, registers to 640x480, 640, 0, 0, RGB565.
// Top level; depends on yrfw_pkg, yrfw_lane, yrfw_addr, yrfw_merge.
module yuyv_to_rgb_framebuffer_writer_core
    import yrfw_pkg::*;
#(
    parameter int MAX_FRAME_DIM = DEF_MAX_FRAME_DIM
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DIM_W-1:0]     cfg_data,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [31:0]          s_axis_tdata,   // yuyv_word[31:0]
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [55:0]          m_axis_tdata,   // byte_address[27:0], pixel_data[51:28], zero
    output logic                 m_axis_tlast,   // second_of_pair
    output logic                 m_axis_tuser    // end_of_frame
);

    logic [DIM_W-1:0] frame_width_reg, frame_height_reg, screen_width_reg;
    logic [OFS_W-1:0] x_offset_reg, y_offset_reg;
    logic             pixel_mode_reg;

    logic             v1_reg, v2_reg;
    logic             adv, accept, load, load_ready;
    logic [PIX_W-1:0] pix0, pix1;
    addr_info_t       info;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= DIM_W'(640);
            frame_height_reg <= DIM_W'(480);
            screen_width_reg <= DIM_W'(640);
            x_offset_reg     <= '0;
            y_offset_reg     <= '0;
            pixel_mode_reg   <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data;
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                REG_SCREEN_WIDTH: screen_width_reg <= cfg_data;
                REG_X_OFFSET:     x_offset_reg     <= cfg_data[OFS_W-1:0];
                REG_Y_OFFSET:     y_offset_reg     <= cfg_data[OFS_W-1:0];
                REG_PIXEL_MODE:   pixel_mode_reg   <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    // Pipeline control: advance unless the last stage holds a pair the merge cannot take
    assign adv           = ~v2_reg | load_ready;
    assign s_axis_tready = adv;
    assign accept        = s_axis_tvalid & adv;
    assign load          = v2_reg & adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= s_axis_tvalid;
            v2_reg <= v1_reg;
        end
    end

    // Lane for the first pixel (Y0)
    yrfw_lane u_lane0 (
        .clk        (clk),
        .en         (adv),
        .y          (s_axis_tdata[7:0]),
        .u          (s_axis_tdata[15:8]),
        .v          (s_axis_tdata[31:24]),
        .pixel_mode (pixel_mode_reg),
        .pix        (pix0)
    );

    // Lane for the second pixel (Y1)
    yrfw_lane u_lane1 (
        .clk        (clk),
        .en         (adv),
        .y          (s_axis_tdata[23:16]),
        .u          (s_axis_tdata[15:8]),
        .v          (s_axis_tdata[31:24]),
        .pixel_mode (pixel_mode_reg),
        .pix        (pix1)
    );

    // Raster position and address terms
    yrfw_addr #(
        .MAX_FRAME_DIM (MAX_FRAME_DIM)
    ) u_addr (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .en           (adv),
        .frame_width  (frame_width_reg),
        .frame_height (frame_height_reg),
        .screen_width (screen_width_reg),
        .x_offset     (x_offset_reg),
        .y_offset     (y_offset_reg),
        .info         (info)
    );

    // Output merge
    yrfw_merge u_merge (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (load),
        .info          (info),
        .pix0          (pix0),
        .pix1          (pix1),
        .pixel_mode    (pixel_mode_reg),
        .load_ready    (load_ready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule
